@@ hdl/qalu_pkg.sv @@
// Shared constants, opcodes, operation classes and Hamilton product tables of the quaternion ALU.
package qalu_pkg;

    localparam int COMP_WIDTH  = 16;
    localparam int FRAC_BITS   = 12;
    localparam int QUEUE_DEPTH = 4;
    localparam int OP_WIDTH    = 4;

    localparam logic [OP_WIDTH-1:0] OP_ADD   = 4'd0;
    localparam logic [OP_WIDTH-1:0] OP_SUB   = 4'd1;
    localparam logic [OP_WIDTH-1:0] OP_PROD  = 4'd2;
    localparam logic [OP_WIDTH-1:0] OP_SCALE = 4'd3;
    localparam logic [OP_WIDTH-1:0] OP_CONJ  = 4'd4;
    localparam logic [OP_WIDTH-1:0] OP_NORM  = 4'd5;
    localparam logic [OP_WIDTH-1:0] OP_INV   = 4'd6;
    localparam logic [OP_WIDTH-1:0] OP_LEN   = 4'd7;
    localparam logic [OP_WIDTH-1:0] OP_SQLEN = 4'd8;

    typedef struct packed {
        logic is_add;
        logic is_sub;
        logic is_prod;
        logic is_scale;
        logic is_conj;
        logic is_norm;
        logic is_inv;
        logic is_len;
        logic is_sqlen;
    } op_class_t;

    localparam int CLASS_W = $bits(op_class_t);

    // Component of b used by each term, and whether the term is subtracted.
    localparam logic [1:0] HAM_B [4][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd2, 2'd3, 2'd0, 2'd1},
        '{2'd3, 2'd2, 2'd1, 2'd0}
    };
    localparam logic HAM_NEG [4][4] = '{
        '{1'b0, 1'b1, 1'b1, 1'b1},
        '{1'b0, 1'b0, 1'b0, 1'b1},
        '{1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b1, 1'b0}
    };

endpackage

@@ hdl/quaternion_alu.sv @@
// Top level of the quaternion ALU: front part, decoupling queue, back pipeline, result queue.
//
//  Channel   Handshake            Fields
//  input     push / full          op, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, factor
//  result    empty / pop          r_w, r_x, r_y, r_z, overflow, zero_divide
//
// One beat is taken and one result is delivered every cycle when neither side stalls.
// Components are Q3.12 by default; most of the back pipeline is made up of the
// square-root stages and the divider stages, one bit each.
// Reset empties both queues and clears every stage's valid bit; there is no other state.
// A full result queue and a waiting result stall the back pipeline; the input queue fills.
module quaternion_alu #(
    parameter int COMP_WIDTH = qalu_pkg::COMP_WIDTH,
    parameter int FRAC_BITS  = qalu_pkg::FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [qalu_pkg::OP_WIDTH-1:0] op,
    input  logic signed [COMP_WIDTH-1:0]  a_w,
    input  logic signed [COMP_WIDTH-1:0]  a_x,
    input  logic signed [COMP_WIDTH-1:0]  a_y,
    input  logic signed [COMP_WIDTH-1:0]  a_z,
    input  logic signed [COMP_WIDTH-1:0]  b_w,
    input  logic signed [COMP_WIDTH-1:0]  b_x,
    input  logic signed [COMP_WIDTH-1:0]  b_y,
    input  logic signed [COMP_WIDTH-1:0]  b_z,
    input  logic signed [COMP_WIDTH-1:0]  factor,
    output logic                          empty,
    input  logic                          pop,
    output logic signed [COMP_WIDTH-1:0]  r_w,
    output logic signed [COMP_WIDTH-1:0]  r_x,
    output logic signed [COMP_WIDTH-1:0]  r_y,
    output logic signed [COMP_WIDTH-1:0]  r_z,
    output logic                          overflow,
    output logic                          zero_divide
);

    localparam int W      = COMP_WIDTH;
    localparam int ITEM_W = qalu_pkg::CLASS_W + 9 * W;
    localparam int RES_W  = 4 * W + 2;

    typedef struct packed {
        logic [3:0][W-1:0] r;
        logic              ov;
        logic              zd;
    } res_t;

    logic              fr_push;
    logic [ITEM_W-1:0] fr_item;
    logic              inq_full;
    logic              inq_empty;
    logic [ITEM_W-1:0] inq_item;
    logic              bk_in_pop;
    logic              bk_out_valid;
    logic [RES_W-1:0]  bk_out_data;
    logic              outq_full;
    logic [RES_W-1:0]  outq_data;
    res_t              res;

    qalu_front #(
        .COMP_WIDTH (COMP_WIDTH)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .op     (op),
        .a_w    (a_w),
        .a_x    (a_x),
        .a_y    (a_y),
        .a_z    (a_z),
        .b_w    (b_w),
        .b_x    (b_x),
        .b_y    (b_y),
        .b_z    (b_z),
        .factor (factor),
        .q_full (inq_full),
        .q_push (fr_push),
        .q_item (fr_item)
    );

    qalu_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (qalu_pkg::QUEUE_DEPTH)
    ) u_in_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fr_push),
        .wdata (fr_item),
        .full  (inq_full),
        .pop   (bk_in_pop),
        .rdata (inq_item),
        .empty (inq_empty)
    );

    qalu_back #(
        .COMP_WIDTH (COMP_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (!inq_empty),
        .in_item   (inq_item),
        .in_pop    (bk_in_pop),
        .out_valid (bk_out_valid),
        .out_data  (bk_out_data),
        .out_ready (!outq_full)
    );

    qalu_fifo #(
        .WIDTH (RES_W),
        .DEPTH (qalu_pkg::QUEUE_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (bk_out_valid),
        .wdata (bk_out_data),
        .full  (outq_full),
        .pop   (pop),
        .rdata (outq_data),
        .empty (empty)
    );

    assign res         = outq_data;
    assign r_w         = res.r[0];
    assign r_x         = res.r[1];
    assign r_y         = res.r[2];
    assign r_z         = res.r[3];
    assign overflow    = res.ov;
    assign zero_divide = res.zd;

    a_back_holds_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        bk_out_valid && outq_full |=> bk_out_valid && $stable(bk_out_data))
        else $error("back pipeline lost or changed a result while the result queue was full");

    a_no_pop_from_empty: assert property (@(posedge clk) disable iff (!rst_n)
        bk_in_pop |-> !inq_empty)
        else $error("back pipeline took a beat from an empty queue");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(overflow && zero_divide))
        else $error("overflow and zero_divide raised together");

    a_zero_divide_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && zero_divide |-> r_w == '0 && r_x == '0 && r_y == '0 && r_z == '0)
        else $error("zero-length result carries non-zero components");

endmodule

@@ hdl/qalu_fifo.sv @@
// Small first-word-fall-through queue used between the ALU's parts and at its output.
module qalu_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = qalu_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ hdl/qalu_front.sv @@
// Front part of the quaternion ALU: takes input beats and classifies the opcode.
module qalu_front #(
    parameter int COMP_WIDTH = qalu_pkg::COMP_WIDTH
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       push,
    output logic                                       full,
    input  logic [qalu_pkg::OP_WIDTH-1:0]              op,
    input  logic signed [COMP_WIDTH-1:0]               a_w,
    input  logic signed [COMP_WIDTH-1:0]               a_x,
    input  logic signed [COMP_WIDTH-1:0]               a_y,
    input  logic signed [COMP_WIDTH-1:0]               a_z,
    input  logic signed [COMP_WIDTH-1:0]               b_w,
    input  logic signed [COMP_WIDTH-1:0]               b_x,
    input  logic signed [COMP_WIDTH-1:0]               b_y,
    input  logic signed [COMP_WIDTH-1:0]               b_z,
    input  logic signed [COMP_WIDTH-1:0]               factor,
    input  logic                                       q_full,
    output logic                                       q_push,
    output logic [qalu_pkg::CLASS_W+9*COMP_WIDTH-1:0] q_item
);

    localparam int W = COMP_WIDTH;

    typedef struct packed {
        qalu_pkg::op_class_t   cls;
        logic [3:0][W-1:0]     a;
        logic [3:0][W-1:0]     b;
        logic [W-1:0]          f;
    } item_t;

    logic                hold_valid_reg, hold_valid_next;
    item_t               hold_item_reg, hold_item_next;
    qalu_pkg::op_class_t cls;
    logic                take, accept;

    assign take   = !hold_valid_reg || !q_full;
    assign full   = !take;
    assign accept = push && take;
    assign q_push = hold_valid_reg;
    assign q_item = hold_item_reg;

    always_comb
    begin
        cls = '0;
        unique case (op)
            qalu_pkg::OP_ADD:   cls.is_add   = 1'b1;
            qalu_pkg::OP_SUB:   cls.is_sub   = 1'b1;
            qalu_pkg::OP_PROD:  cls.is_prod  = 1'b1;
            qalu_pkg::OP_SCALE: cls.is_scale = 1'b1;
            qalu_pkg::OP_CONJ:  cls.is_conj  = 1'b1;
            qalu_pkg::OP_NORM:  cls.is_norm  = 1'b1;
            qalu_pkg::OP_INV:   cls.is_inv   = 1'b1;
            qalu_pkg::OP_LEN:   cls.is_len   = 1'b1;
            qalu_pkg::OP_SQLEN: cls.is_sqlen = 1'b1;
            default:            cls = '0;
        endcase
        hold_item_next.cls = cls;
        hold_item_next.a   = {a_z, a_y, a_x, a_w};
        hold_item_next.b   = {b_z, b_y, b_x, b_w};
        hold_item_next.f   = factor;
        hold_valid_next    = accept ? 1'b1 : (q_full ? hold_valid_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_item_reg <= hold_item_next;
        end
    end

endmodule

@@ hdl/qalu_back.sv @@
// Back part of the quaternion ALU: multiply, sum, square-root and divide pipeline.
module qalu_back #(
    parameter int COMP_WIDTH = qalu_pkg::COMP_WIDTH,
    parameter int FRAC_BITS  = qalu_pkg::FRAC_BITS
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    input  logic [qalu_pkg::CLASS_W+9*COMP_WIDTH-1:0] in_item,
    output logic                                       in_pop,
    output logic                                       out_valid,
    output logic [4*COMP_WIDTH+1:0]                    out_data,
    input  logic                                       out_ready
);

    localparam int W    = COMP_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int RB   = W + 1;
    localparam int SW   = 2 * RB;
    localparam int REMW = RB + 2;
    localparam int SQW  = 2 * W + 2 - F;
    localparam int LW   = RB + 1;
    localparam int DW   = (LW > SQW) ? LW : SQW;
    localparam int NW   = ((W + F > DW) ? W + F : DW) + 1;
    localparam int XW   = 2 * W + 4;
    localparam longint unsigned LIM   = 64'd1 << (W - 1);
    localparam longint unsigned ROUND = 64'd1 << (F - 1);

    typedef struct packed {
        qalu_pkg::op_class_t   cls;
        logic [3:0][W-1:0]     a;
        logic [3:0][W-1:0]     b;
        logic [W-1:0]          f;
    } item_t;

    typedef struct packed {
        qalu_pkg::op_class_t        cls;
        logic [3:0][W-1:0]          a;
        logic [3:0][3:0][2*W-1:0]   prod;
        logic [3:0][2*W-1:0]        sc;
        logic [3:0][2*W-1:0]        sq;
        logic [3:0][W-1:0]          r;
        logic                       ov;
    } mul_t;

    typedef struct packed {
        qalu_pkg::op_class_t   cls;
        logic [3:0][W-1:0]     a;
        logic [3:0][W-1:0]     r;
        logic                  ov;
        logic [SW-1:0]         s;
        logic [RB-1:0]         root;
        logic [REMW-1:0]       rem;
    } sq_t;

    typedef struct packed {
        qalu_pkg::op_class_t   cls;
        logic [3:0][W-1:0]     r;
        logic                  ov;
        logic                  zero;
        logic [3:0]            neg;
        logic [3:0]            nz;
        logic [DW-1:0]         d;
        logic [3:0][NW-1:0]    n;
        logic [3:0][NW-1:0]    q;
        logic [3:0][DW:0]      rem;
    } dv_t;

    typedef struct packed {
        logic [3:0][W-1:0] r;
        logic              ov;
        logic              zd;
    } res_t;

    function automatic logic [W:0] sat_fn(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        hi = XW'(LIM - 1);
        lo = ~hi;
        if (v > hi)
        begin
            return {1'b1, hi[W-1:0]};
        end
        else if (v < lo)
        begin
            return {1'b1, lo[W-1:0]};
        end
        return {1'b0, v[W-1:0]};
    endfunction

    logic  adv;
    logic  a_valid_reg;
    item_t a_item_reg;
    mul_t  m_next;
    logic  b_valid_reg;
    mul_t  b_reg;
    sq_t   c_next;
    logic  sq_valid_reg [RB+1];
    sq_t   sq_reg [RB+1];
    dv_t   d0_next;
    logic  dv_valid_reg [NW+1];
    dv_t   dv_reg [NW+1];
    res_t  res;

    assign adv       = !dv_valid_reg[NW] || out_ready;
    assign in_pop    = adv && in_valid;
    assign out_valid = dv_valid_reg[NW];
    assign out_data  = res;

    // Products, squares and the exact operations.
    always_comb
    begin
        logic [W:0] s_add;
        logic [W:0] s_sub;
        logic [W:0] s_neg;
        m_next.cls = a_item_reg.cls;
        m_next.a   = a_item_reg.a;
        m_next.r   = '0;
        m_next.ov  = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                m_next.prod[i][k] = (2*W)'($signed((2*W)'($signed(a_item_reg.a[k])))
                    * $signed((2*W)'($signed(a_item_reg.b[qalu_pkg::HAM_B[i][k]]))));
            end
            m_next.sc[i] = (2*W)'($signed((2*W)'($signed(a_item_reg.a[i])))
                * $signed((2*W)'($signed(a_item_reg.f))));
            m_next.sq[i] = (2*W)'($signed((2*W)'($signed(a_item_reg.a[i])))
                * $signed((2*W)'($signed(a_item_reg.a[i]))));
            s_add = sat_fn(XW'($signed(a_item_reg.a[i])) + XW'($signed(a_item_reg.b[i])));
            s_sub = sat_fn(XW'($signed(a_item_reg.a[i])) - XW'($signed(a_item_reg.b[i])));
            s_neg = sat_fn(-XW'($signed(a_item_reg.a[i])));
            priority if (a_item_reg.cls.is_add)
            begin
                m_next.r[i] = s_add[W-1:0];
                m_next.ov   = m_next.ov | s_add[W];
            end
            else if (a_item_reg.cls.is_sub)
            begin
                m_next.r[i] = s_sub[W-1:0];
                m_next.ov   = m_next.ov | s_sub[W];
            end
            else if (a_item_reg.cls.is_conj)
            begin
                if (i == 0)
                begin
                    m_next.r[i] = a_item_reg.a[i];
                end
                else
                begin
                    m_next.r[i] = s_neg[W-1:0];
                    m_next.ov   = m_next.ov | s_neg[W];
                end
            end
            else
            begin
                m_next.r[i] = '0;
            end
        end
    end

    // Sums of products with rounding, and the squared length.
    always_comb
    begin
        logic signed [XW-1:0] acc;
        logic signed [XW-1:0] rnd;
        logic [W:0]           st;
        logic [SW-1:0]        ssum;
        c_next.cls  = b_reg.cls;
        c_next.a    = b_reg.a;
        c_next.r    = b_reg.r;
        c_next.ov   = b_reg.ov;
        c_next.root = '0;
        c_next.rem  = '0;
        ssum        = '0;
        for (int i = 0; i < 4; i++)
        begin
            ssum = ssum + SW'(b_reg.sq[i]);
        end
        c_next.s = ssum;
        for (int i = 0; i < 4; i++)
        begin
            acc = '0;
            if (b_reg.cls.is_prod)
            begin
                for (int k = 0; k < 4; k++)
                begin
                    if (qalu_pkg::HAM_NEG[i][k])
                    begin
                        acc = acc - XW'($signed(b_reg.prod[i][k]));
                    end
                    else
                    begin
                        acc = acc + XW'($signed(b_reg.prod[i][k]));
                    end
                end
            end
            else
            begin
                acc = XW'($signed(b_reg.sc[i]));
            end
            rnd = (acc + $signed(XW'(ROUND))) >>> F;
            st  = sat_fn(rnd);
            if (b_reg.cls.is_prod || b_reg.cls.is_scale)
            begin
                c_next.r[i] = st[W-1:0];
                c_next.ov   = c_next.ov | st[W];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
            sq_valid_reg[0] <= 1'b0;
            dv_valid_reg[0] <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg     <= in_valid;
            b_valid_reg     <= a_valid_reg;
            sq_valid_reg[0] <= b_valid_reg;
            dv_valid_reg[0] <= sq_valid_reg[RB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_item_reg <= in_item;
            b_reg      <= m_next;
            sq_reg[0]  <= c_next;
            dv_reg[0]  <= d0_next;
        end
    end

    // Square root, one result bit per stage.
    for (genvar j = 0; j < RB; j++)
    begin : g_sqrt
        localparam int BI = RB - 1 - j;
        sq_t             sq_next;
        logic [REMW-1:0] remsh;
        logic [REMW-1:0] trial;
        logic            ge;

        always_comb
        begin
            remsh        = {sq_reg[j].rem[REMW-3:0], sq_reg[j].s[2*BI+1 -: 2]};
            trial        = {sq_reg[j].root, 2'b01};
            ge           = (remsh >= trial);
            sq_next      = sq_reg[j];
            sq_next.rem  = ge ? remsh - trial : remsh;
            sq_next.root = {sq_reg[j].root[RB-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[j+1] <= 1'b0;
            end
            else if (adv)
            begin
                sq_valid_reg[j+1] <= sq_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_reg[j+1] <= sq_next;
            end
        end
    end

    // Length rounding, divisor choice, numerators and the LEN and SQLEN results.
    always_comb
    begin
        sq_t            t;
        logic [LW-1:0]  len;
        logic [SQW-1:0] sql;
        logic [DW-1:0]  dv;
        logic [W-1:0]   mag;
        t            = sq_reg[RB];
        len          = LW'(t.root) + LW'(t.rem > REMW'(t.root));
        sql          = SQW'(t.s[SW-1:F]) + SQW'(t.s[F-1]);
        dv           = t.cls.is_norm ? DW'(len) : DW'(sql);
        d0_next.cls  = t.cls;
        d0_next.r    = t.r;
        d0_next.ov   = t.ov;
        d0_next.zero = (t.s == '0);
        d0_next.d    = dv;
        d0_next.q    = '0;
        d0_next.rem  = '0;
        for (int i = 0; i < 4; i++)
        begin
            d0_next.neg[i] = t.a[i][W-1] ^ (t.cls.is_inv && (i != 0));
            d0_next.nz[i]  = (t.a[i] != '0);
            mag            = t.a[i][W-1] ? W'(0) - t.a[i] : t.a[i];
            d0_next.n[i]   = NW'({mag, {F{1'b0}}}) + NW'(dv >> 1);
        end
        if (t.cls.is_len)
        begin
            d0_next.r = '0;
            if (64'(len) > LIM - 1)
            begin
                d0_next.r[0] = W'(LIM - 1);
                d0_next.ov   = 1'b1;
            end
            else
            begin
                d0_next.r[0] = W'(len);
            end
        end
        if (t.cls.is_sqlen)
        begin
            d0_next.r = '0;
            if (64'(sql) > LIM - 1)
            begin
                d0_next.r[0] = W'(LIM - 1);
                d0_next.ov   = 1'b1;
            end
            else
            begin
                d0_next.r[0] = W'(sql);
            end
        end
    end

    // Restoring division of four lanes, one quotient bit per stage.
    for (genvar j = 0; j < NW; j++)
    begin : g_div
        localparam int BI = NW - 1 - j;
        dv_t dv_next;

        always_comb
        begin
            logic [DW:0] remsh;
            logic        ge;
            dv_next = dv_reg[j];
            for (int l = 0; l < 4; l++)
            begin
                remsh          = {dv_reg[j].rem[l][DW-1:0], dv_reg[j].n[l][BI]};
                ge             = (remsh >= {1'b0, dv_reg[j].d});
                dv_next.rem[l] = ge ? remsh - {1'b0, dv_reg[j].d} : remsh;
                dv_next.q[l]   = {dv_reg[j].q[l][NW-2:0], ge};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j+1] <= 1'b0;
            end
            else if (adv)
            begin
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[j+1] <= dv_next;
            end
        end
    end

    // Signs, saturation and the zero-length case.
    always_comb
    begin
        dv_t t;
        t      = dv_reg[NW];
        res.r  = t.r;
        res.ov = t.ov;
        res.zd = 1'b0;
        if (t.cls.is_norm || t.cls.is_inv)
        begin
            res.ov = 1'b0;
            if (t.zero)
            begin
                res.r  = '0;
                res.zd = 1'b1;
            end
            else
            begin
                for (int l = 0; l < 4; l++)
                begin
                    if (!t.nz[l])
                    begin
                        res.r[l] = '0;
                    end
                    else if (t.neg[l])
                    begin
                        if (64'(t.q[l]) > LIM)
                        begin
                            res.r[l] = W'(LIM);
                            res.ov   = 1'b1;
                        end
                        else
                        begin
                            res.r[l] = W'(0) - t.q[l][W-1:0];
                        end
                    end
                    else if (64'(t.q[l]) > LIM - 1)
                    begin
                        res.r[l] = W'(LIM - 1);
                        res.ov   = 1'b1;
                    end
                    else
                    begin
                        res.r[l] = t.q[l][W-1:0];
                    end
                end
            end
        end
    end

endmodule

@@ tb/qalu_checker.sv @@
// Checker for the quaternion ALU: watches both channels, predicts each result and compares.
`timescale 1ns / 100ps

module qalu_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    input  logic                                   full,
    input  logic [qalu_pkg::OP_WIDTH-1:0]          op,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] a_w,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] a_x,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] a_y,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] a_z,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] b_w,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] b_x,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] b_y,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] b_z,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] factor,
    input  logic                                   empty,
    input  logic                                   pop,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] r_w,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] r_x,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] r_y,
    input  logic signed [qalu_pkg::COMP_WIDTH-1:0] r_z,
    input  logic                                   overflow,
    input  logic                                   zero_divide,
    output int                                     fail_count,
    output int                                     pending,
    output int                                     results_seen
);

    localparam int CW = qalu_pkg::COMP_WIDTH;
    localparam int FB = qalu_pkg::FRAC_BITS;

    typedef struct packed {
        logic signed [CW-1:0] w;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 ovf;
        logic                 zdiv;
    } quat_result_t;

    localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint CMIN = -CMAX - 1;

    quat_result_t expected_q[$];

    function automatic longint clamp(input longint v, inout logic ovf);
        if (v > CMAX)
        begin
            ovf = 1'b1;
            return CMAX;
        end
        if (v < CMIN)
        begin
            ovf = 1'b1;
            return CMIN;
        end
        return v;
    endfunction

    // Rounds a value with 2*FRAC_BITS fraction bits half up to FRAC_BITS.
    function automatic longint round_prod(input longint v);
        return (v + (64'sd1 <<< (FB - 1))) >>> FB;
    endfunction

    function automatic longint isqrt_round(input longint unsigned s);
        longint unsigned lo, hi, mid;
        lo = 0;
        hi = 64'd4294967295;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= s)
                lo = mid;
            else
                hi = mid - 1;
        end
        if (s - lo * lo > lo)
            lo++;
        return lo;
    endfunction

    function automatic longint div_near(input longint n, input longint unsigned d,
                                        inout logic ovf);
        longint unsigned mag, q;
        if (n == 0)
            return 0;
        if (d == 0)
            return clamp(n > 0 ? CMAX + 1 : CMIN - 1, ovf);
        mag = n < 0 ? -n : n;
        q = (mag + d / 2) / d;
        return clamp(n < 0 ? -longint'(q) : longint'(q), ovf);
    endfunction

    function automatic quat_result_t predict_quat(
        input logic [qalu_pkg::OP_WIDTH-1:0] opc, input longint qa[4], input longint qb[4],
        input longint fac);
        quat_result_t res;
        longint r[4];
        longint acc, den;
        longint unsigned ssum;
        logic ovf, zdiv;
        ovf = 1'b0;
        zdiv = 1'b0;
        r = '{0, 0, 0, 0};
        ssum = 0;
        for (int i = 0; i < 4; i++)
            ssum += qa[i] * qa[i];
        case (opc)
            qalu_pkg::OP_ADD:
                for (int i = 0; i < 4; i++)
                    r[i] = clamp(qa[i] + qb[i], ovf);
            qalu_pkg::OP_SUB:
                for (int i = 0; i < 4; i++)
                    r[i] = clamp(qa[i] - qb[i], ovf);
            qalu_pkg::OP_PROD:
                for (int i = 0; i < 4; i++)
                begin
                    acc = 0;
                    for (int k = 0; k < 4; k++)
                        if (qalu_pkg::HAM_NEG[i][k])
                            acc -= qa[k] * qb[qalu_pkg::HAM_B[i][k]];
                        else
                            acc += qa[k] * qb[qalu_pkg::HAM_B[i][k]];
                    r[i] = clamp(round_prod(acc), ovf);
                end
            qalu_pkg::OP_SCALE:
                for (int i = 0; i < 4; i++)
                    r[i] = clamp(round_prod(qa[i] * fac), ovf);
            qalu_pkg::OP_CONJ:
            begin
                r[0] = clamp(qa[0], ovf);
                for (int i = 1; i < 4; i++)
                    r[i] = clamp(-qa[i], ovf);
            end
            qalu_pkg::OP_NORM:
                if (ssum == 0)
                    zdiv = 1'b1;
                else
                begin
                    den = isqrt_round(ssum);
                    for (int i = 0; i < 4; i++)
                        r[i] = div_near(qa[i] <<< FB, den, ovf);
                end
            qalu_pkg::OP_INV:
                if (ssum == 0)
                    zdiv = 1'b1;
                else
                begin
                    den = (ssum >> FB) + ((ssum >> (FB - 1)) & 1);
                    for (int i = 0; i < 4; i++)
                        r[i] = div_near((i == 0 ? qa[i] : -qa[i]) <<< FB, den, ovf);
                end
            qalu_pkg::OP_LEN:
                r[0] = clamp(isqrt_round(ssum), ovf);
            qalu_pkg::OP_SQLEN:
                r[0] = clamp((ssum >> FB) + ((ssum >> (FB - 1)) & 1), ovf);
            default:
                ;
        endcase
        res.w = r[0];
        res.x = r[1];
        res.y = r[2];
        res.z = r[3];
        res.ovf = ovf;
        res.zdiv = zdiv;
        return res;
    endfunction

    task automatic compare_field(input string fname, input longint exp_v, input longint act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, actual %0d", fname, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        longint qa[4], qb[4];
        quat_result_t exp_r;
        if (rst_n && push && !full)
        begin
            qa = '{a_w, a_x, a_y, a_z};
            qb = '{b_w, b_x, b_y, b_z};
            expected_q.push_back(predict_quat(op, qa, qb, factor));
        end
        if (rst_n && pop && !empty)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $error("result beat with no expectation waiting");
                fail_count++;
            end
            else
            begin
                exp_r = expected_q.pop_front();
                compare_field("r_w", exp_r.w, r_w);
                compare_field("r_x", exp_r.x, r_x);
                compare_field("r_y", exp_r.y, r_y);
                compare_field("r_z", exp_r.z, r_z);
                compare_field("overflow", exp_r.ovf, overflow);
                compare_field("zero_divide", exp_r.zdiv, zero_divide);
            end
        end
        pending = expected_q.size();
    end

endmodule

@@ tb/tb.sv @@
// Testbench top of the quaternion ALU: clock, reset, stimulus, result draining and verdict.
`timescale 1ns / 100ps

module tb;

    localparam int  CW          = qalu_pkg::COMP_WIDTH;
    localparam int  OPW         = qalu_pkg::OP_WIDTH;
    localparam int  N_RANDOM    = 450;
    localparam int  DRAIN_WAIT  = 200;
    localparam int  CYCLE_LIMIT = 200000;

    logic                 clk;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic [OPW-1:0]       op;
    logic signed [CW-1:0] a_w, a_x, a_y, a_z;
    logic signed [CW-1:0] b_w, b_x, b_y, b_z;
    logic signed [CW-1:0] factor;
    logic                 empty;
    logic                 pop;
    logic signed [CW-1:0] r_w, r_x, r_y, r_z;
    logic                 overflow;
    logic                 zero_divide;
    int                   fail_count;
    int                   pending;
    int                   results_seen;
    int                   items_sent;
    int                   cycle_count;
    bit                   hold_off;

    quaternion_alu dut (.*);

    qalu_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic signed [CW-1:0] rand_comp();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return CW'(int'($urandom_range(0, 15)) - 8);
            4: return CW'(int'($urandom_range(0, 16383)) - 8192);
            default: return CW'($urandom);
        endcase
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    endfunction

    // Presents one beat and holds it until the block takes it.
    task automatic send_beat(input logic [OPW-1:0] opc,
                             input logic signed [CW-1:0] q[9]);
        op <= opc;
        a_w <= q[0]; a_x <= q[1]; a_y <= q[2]; a_z <= q[3];
        b_w <= q[4]; b_x <= q[5]; b_y <= q[6]; b_z <= q[7];
        factor <= q[8];
        push <= 1'b1;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic idle_sender(input int n);
        if (n > 0)
        begin
            push <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    always @(negedge clk)
    begin
        if (!rst_n || hold_off)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(0, 3) != 0);
    end

    initial
    begin
        logic signed [CW-1:0] q[9];
        int drain;
        rst_n = 1'b0;
        push = 1'b0;
        hold_off = 1'b0;
        items_sent = 0;
        op = qalu_pkg::OP_ADD;
        {a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, factor} = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed beats: extremes, every opcode, zero and tiny quaternions.
        for (int k = 0; k < 16; k++)
        begin
            for (int j = 0; j < 9; j++)
                q[j] = (k % 2 == 0) ? 16'sh7fff : 16'sh8000;
            send_beat(OPW'(k), q);
        end
        q = '{default: 16'sh0000};
        send_beat(qalu_pkg::OP_NORM, q);
        send_beat(qalu_pkg::OP_INV, q);
        q[0] = 16'sh0001;
        send_beat(qalu_pkg::OP_INV, q);
        q[2] = -16'sh0001;
        send_beat(qalu_pkg::OP_INV, q);
        q = '{16'sh1000, 16'sh0000, 16'sh0000, 16'sh0000,
              16'sh0000, 16'sh1000, 16'sh0000, 16'sh0000, 16'sh1000};
        send_beat(qalu_pkg::OP_PROD, q);
        send_beat(qalu_pkg::OP_NORM, q);
        q[1] = 16'sh8000;
        send_beat(qalu_pkg::OP_CONJ, q);

        // The receiver stops while beats keep coming, so both queues fill.
        fork
            begin
                hold_off = 1'b1;
                repeat (120) @(negedge clk);
                hold_off = 1'b0;
            end
        join_none

        for (int n = 0; n < N_RANDOM; n++)
        begin
            for (int j = 0; j < 9; j++)
                q[j] = rand_comp();
            send_beat($urandom_range(0, 9) == 0 ? OPW'($urandom_range(9, 15))
                                                  : OPW'($urandom_range(0, 8)), q);
            if (n > 100 && $urandom_range(0, 2) == 0)
                idle_sender(gap_len());
        end
        push <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        drain = 0;
        while (drain < DRAIN_WAIT)
        begin
            @(negedge clk);
            drain++;
        end

        $display("Sent %0d beats covering all opcodes, limits and zero-length cases.",
                 items_sent);
        $display("Checked %0d result beats with random stalls on both sides.", results_seen);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
